@@ sv/cidm_pkg.sv @@
`timescale 1ns / 1ps

package cidm_pkg;

	// defaults for the top level parameters
	localparam int NUM_KINDS_DEF   = 4;
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int VALUE_WIDTH_DEF = 16;

	// fixed geometry of the direct table for standard identifiers
	localparam int STD_TABLE_DEPTH = 2048;
	localparam int STD_ID_W        = 11;

	// field widths
	localparam int OPCODE_W = 2;
	localparam int KIND_FW  = 3;
	localparam int ID_W     = 29;
	localparam int KEY_W    = ID_W + 1;
	localparam int MV_W     = 16;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 16;
	localparam int COUNT_W  = 9;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 9;
	localparam int NUM_COUNTS = 4;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_LOOKUP      = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD         = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LOAD_SORTED = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_LOAD_DIRECT = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_KIND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SIMPLE_UNSET = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISMATCH     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_RESERVED     = 3'd5;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_KINDS_IN_USE = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_SEARCH_MASK  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_DIRECT_MASK  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_COUNT_K0     = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_COUNT_K1     = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_COUNT_K2     = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_COUNT_K3     = 3'd6;

	typedef struct packed {
		logic start;
		logic wr;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic found;
	} srch_rsp_t;

endpackage

@@ sv/cidm_search.sv @@
`timescale 1ns / 1ps

module cidm_search #(
	parameter int NUM_KINDS   = cidm_pkg::NUM_KINDS_DEF,
	parameter int MAX_ENTRIES = cidm_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_WIDTH = cidm_pkg::VALUE_WIDTH_DEF,
	localparam int KIND_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1,
	localparam int EW     = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cidm_pkg::srch_req_t           req,
	input  logic [KIND_W-1:0]             kind,
	input  logic [cidm_pkg::KEY_W-1:0]    key,
	input  logic [EW-1:0]                 hi_init,
	input  logic [cidm_pkg::POS_W-1:0]    wr_pos,
	input  logic [VALUE_WIDTH-1:0]        wr_val,
	output cidm_pkg::srch_rsp_t           rsp,
	output logic [VALUE_WIDTH-1:0]        val
);

	localparam int DEPTH = NUM_KINDS * MAX_ENTRIES;
	localparam int SA_W  = $clog2(DEPTH);
	localparam int KW    = cidm_pkg::KEY_W;
	localparam int MW    = KW + VALUE_WIDTH;

	localparam logic [1:0] SS_IDLE = 2'd0;
	localparam logic [1:0] SS_READ = 2'd1;
	localparam logic [1:0] SS_CMP  = 2'd2;

	logic [MW-1:0]          mem [DEPTH];
	logic [MW-1:0]          rd_q;
	logic [1:0]             state_q;
	logic [EW-1:0]          lo_q, hi_q, mid_q;
	logic [KW-1:0]          key_q;
	logic [SA_W-1:0]        base_q;
	logic                   done_q, found_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic [SA_W-1:0]        base_now;
	logic [SA_W-1:0]        waddr, raddr;
	logic [EW:0]            sum;
	logic [EW-1:0]          mid;
	logic [KW-1:0]          probe;
	logic [VALUE_WIDTH-1:0] pval;
	logic                   lt;
	logic [EW-1:0]          nlo, nhi;

	assign base_now = SA_W'(kind * MAX_ENTRIES);
	assign waddr    = base_now + SA_W'(wr_pos);
	assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = sum[EW:1];
	assign raddr    = base_q + SA_W'(mid);
	assign probe    = rd_q[MW-1:VALUE_WIDTH];
	assign pval     = rd_q[VALUE_WIDTH-1:0];
	assign lt       = key_q < probe;
	assign nlo      = lt ? lo_q : mid_q + EW'(1);
	assign nhi      = lt ? mid_q : hi_q;

	// sorted key and index memory, one row per entry
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[waddr] <= {key, wr_val};
		end
		if (state_q == SS_READ) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SS_IDLE: begin
					if (req.start) begin
						if (hi_init == '0) begin
							done_q  <= 1'b1;
							found_q <= 1'b0;
						end else begin
							state_q <= SS_READ;
						end
					end
				end
				SS_READ: begin
					state_q <= SS_CMP;
				end
				SS_CMP: begin
					if (key_q == probe) begin
						done_q  <= 1'b1;
						found_q <= 1'b1;
						state_q <= SS_IDLE;
					end else if (nlo < nhi) begin
						state_q <= SS_READ;
					end else begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						state_q <= SS_IDLE;
					end
				end
				default: begin
					state_q <= SS_IDLE;
				end
			endcase
		end
	end

	// search window and probe bookkeeping
	always_ff @(posedge clk) begin
		if (state_q == SS_IDLE && req.start) begin
			lo_q   <= '0;
			hi_q   <= hi_init;
			key_q  <= key;
			base_q <= base_now;
		end else if (state_q == SS_READ) begin
			mid_q <= mid;
		end else if (state_q == SS_CMP) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			val_q <= pval;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.found = found_q;
	assign val       = val_q;

endmodule

@@ sv/can_id_to_index_map.sv @@
`timescale 1ns / 1ps

// Maps an event kind and a CAN identifier to an index. One transaction is
// taken at a time: s_tready is high only while the block is idle. A simple
// mode kind, a table load or a rejected kind is answered from the execute
// state; a direct table read first passes through a registered table read. A
// binary search over the sorted table does a registered memory read, then a
// compare, for each probe on one shared compare unit, halving the window until
// the key is found or the window is empty. The result sits in an output
// register, so a stalled m_tready holds only the next result, not the
// acceptance of the current item. The sorted and direct tables come up
// undefined and must be loaded before use.
module can_id_to_index_map #(
	parameter int NUM_KINDS   = cidm_pkg::NUM_KINDS_DEF,
	parameter int MAX_ENTRIES = cidm_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_WIDTH = cidm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cidm_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [cidm_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// can_id[28:0], map_value[44:29], entry_position[52:45], zeros above
	input  logic [55:0]                 s_tdata,
	// opcode[1:0], kind[4:2], is_extended[5]
	input  logic [5:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status[2:0], index_out[18:3], zeros above
	output logic [23:0]                 m_tdata
);

	localparam int KIND_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
	localparam int EW     = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (EW > cidm_pkg::COUNT_W) ? EW : cidm_pkg::COUNT_W;
	localparam int CW     = (VALUE_WIDTH > cidm_pkg::MV_W) ? VALUE_WIDTH : cidm_pkg::MV_W;
	localparam int DDEPTH = NUM_KINDS * cidm_pkg::STD_TABLE_DEPTH;
	localparam int DA_W   = $clog2(DDEPTH);
	localparam logic [VALUE_WIDTH-1:0] VMASK = {VALUE_WIDTH{1'b1}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DRD  = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0] state_q, state_nxt;

	// configuration
	logic [2:0]                     kinds_q;
	logic [3:0]                     srch_mask_q;
	logic [3:0]                     dir_mask_q;
	logic [cidm_pkg::COUNT_W-1:0]   count_q [cidm_pkg::NUM_COUNTS];

	// accepted transaction
	logic [cidm_pkg::OPCODE_W-1:0]  op_q;
	logic [cidm_pkg::KIND_FW-1:0]   kind_q;
	logic [cidm_pkg::ID_W-1:0]      id_q;
	logic                           ext_q;
	logic [cidm_pkg::MV_W-1:0]      mv_q;
	logic [cidm_pkg::POS_W-1:0]     pos_q;

	logic [VALUE_WIDTH-1:0]         simple_q [NUM_KINDS];
	logic [VALUE_WIDTH-1:0]         dir_mem [DDEPTH];
	logic [VALUE_WIDTH-1:0]         dir_rd_q;

	logic [cidm_pkg::STATUS_W-1:0]  res_st_q, res_st_nxt;
	logic [cidm_pkg::INDEX_W-1:0]   res_idx_q, res_idx_nxt;
	logic [cidm_pkg::STATUS_W-1:0]  out_st_q;
	logic [cidm_pkg::INDEX_W-1:0]   out_idx_q;
	logic                           out_valid_q;

	logic                           in_xact, out_free, res_we;
	logic                           kind_ok, is_search, use_direct, pos_ok;
	logic [1:0]                     k2;
	logic [VALUE_WIDTH-1:0]         sv;
	logic                           sv_we, dir_we, dir_re;
	logic [DA_W-1:0]                daddr;
	logic [cidm_pkg::COUNT_W-1:0]   cnt;
	logic [EW-1:0]                  hi_init;
	logic                           fin_found;
	logic [VALUE_WIDTH-1:0]         fin_val;
	cidm_pkg::srch_req_t            sreq;
	cidm_pkg::srch_rsp_t            srsp;
	logic [VALUE_WIDTH-1:0]         srch_val;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xact  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_idx_q, out_st_q};

	assign k2         = kind_q[1:0];
	assign kind_ok    = (kind_q < kinds_q) && (kind_q < cidm_pkg::KIND_FW'(NUM_KINDS));
	assign is_search  = srch_mask_q[k2];
	assign use_direct = !ext_q && dir_mask_q[k2];
	assign sv         = simple_q[kind_q[KIND_W-1:0]];
	assign daddr      = DA_W'({kind_q[KIND_W-1:0], id_q[cidm_pkg::STD_ID_W-1:0]});
	assign cnt        = count_q[k2];
	// counts above the table size saturate
	assign hi_init    = (CMP_W'(cnt) > CMP_W'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(cnt);
	assign pos_ok     = CMP_W'(pos_q) < CMP_W'(MAX_ENTRIES);
	assign fin_found  = (state_q == ST_DRD) || srsp.found;
	assign fin_val    = (state_q == ST_DRD) ? dir_rd_q : srch_val;

	always_comb begin
		state_nxt   = state_q;
		res_we      = 1'b0;
		res_st_nxt  = cidm_pkg::ST_OK;
		res_idx_nxt = '0;
		sv_we       = 1'b0;
		dir_we      = 1'b0;
		dir_re      = 1'b0;
		sreq.start  = 1'b0;
		sreq.wr     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!kind_ok) begin
					res_we     = 1'b1;
					res_st_nxt = cidm_pkg::ST_BAD_KIND;
					state_nxt  = ST_RESP;
				end else begin
					unique case (op_q)
						cidm_pkg::OP_LOOKUP, cidm_pkg::OP_ADD: begin
							if (!is_search) begin
								res_we    = 1'b1;
								state_nxt = ST_RESP;
								if (op_q == cidm_pkg::OP_LOOKUP) begin
									if (sv == VMASK) begin
										res_st_nxt = cidm_pkg::ST_SIMPLE_UNSET;
									end else begin
										res_idx_nxt = cidm_pkg::INDEX_W'(sv);
									end
								end else if (CW'(mv_q) >= CW'(VMASK)) begin
									res_st_nxt = cidm_pkg::ST_RESERVED;
								end else if (sv == VMASK) begin
									sv_we = 1'b1;
								end else if (CW'(sv) != CW'(mv_q)) begin
									res_st_nxt = cidm_pkg::ST_MISMATCH;
								end
							end else if (use_direct) begin
								dir_re    = 1'b1;
								state_nxt = ST_DRD;
							end else begin
								sreq.start = 1'b1;
								state_nxt  = ST_SRCH;
							end
						end
						cidm_pkg::OP_LOAD_SORTED: begin
							sreq.wr   = pos_ok;
							res_we    = 1'b1;
							state_nxt = ST_RESP;
						end
						cidm_pkg::OP_LOAD_DIRECT: begin
							dir_we    = 1'b1;
							res_we    = 1'b1;
							state_nxt = ST_RESP;
						end
						default: begin
							state_nxt = ST_RESP;
						end
					endcase
				end
			end
			ST_DRD, ST_SRCH: begin
				if (state_q == ST_DRD || srsp.done) begin
					res_we    = 1'b1;
					state_nxt = ST_RESP;
					if (!fin_found) begin
						res_st_nxt = cidm_pkg::ST_NOT_FOUND;
					end else if (op_q == cidm_pkg::OP_LOOKUP) begin
						res_idx_nxt = cidm_pkg::INDEX_W'(fin_val);
					end else if (CW'(fin_val) != CW'(mv_q)) begin
						res_st_nxt = cidm_pkg::ST_MISMATCH;
					end
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			kinds_q     <= 3'd4;
			srch_mask_q <= '0;
			dir_mask_q  <= '0;
			for (int i = 0; i < cidm_pkg::NUM_COUNTS; i++) begin
				count_q[i] <= '0;
			end
			for (int i = 0; i < NUM_KINDS; i++) begin
				simple_q[i] <= VMASK;
			end
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (sv_we) begin
				simple_q[kind_q[KIND_W-1:0]] <= VALUE_WIDTH'(mv_q);
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					cidm_pkg::CFG_KINDS_IN_USE: kinds_q     <= cfg_wdata[2:0];
					cidm_pkg::CFG_SEARCH_MASK:  srch_mask_q <= cfg_wdata[3:0];
					cidm_pkg::CFG_DIRECT_MASK:  dir_mask_q  <= cfg_wdata[3:0];
					cidm_pkg::CFG_COUNT_K0:     count_q[0]  <= cfg_wdata;
					cidm_pkg::CFG_COUNT_K1:     count_q[1]  <= cfg_wdata;
					cidm_pkg::CFG_COUNT_K2:     count_q[2]  <= cfg_wdata;
					cidm_pkg::CFG_COUNT_K3:     count_q[3]  <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// transaction fields, result and output payload
	always_ff @(posedge clk) begin
		if (in_xact) begin
			id_q   <= s_tdata[28:0];
			mv_q   <= s_tdata[44:29];
			pos_q  <= s_tdata[52:45];
			op_q   <= s_tuser[1:0];
			kind_q <= s_tuser[4:2];
			ext_q  <= s_tuser[5];
		end
		if (res_we) begin
			res_st_q  <= res_st_nxt;
			res_idx_q <= res_idx_nxt;
		end
		if (state_q == ST_RESP && out_free) begin
			out_st_q  <= res_st_q;
			out_idx_q <= res_idx_q;
		end
	end

	// direct table for standard identifiers, one block of rows per kind
	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[daddr] <= VALUE_WIDTH'(mv_q);
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[daddr];
		end
	end

	cidm_search #(
		.NUM_KINDS   (NUM_KINDS),
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq),
		.kind    (kind_q[KIND_W-1:0]),
		.key     ({ext_q, id_q}),
		.hi_init (hi_init),
		.wr_pos  (pos_q),
		.wr_val  (VALUE_WIDTH'(mv_q)),
		.rsp     (srsp),
		.val     (srch_val)
	);

`ifndef SYNTHESIS
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !s_tready)
		else $error("transaction accepted while the previous one is in flight");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srsp.done |-> state_q == ST_SRCH)
		else $error("search finished outside the search state");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_st_q <= cidm_pkg::ST_RESERVED)
		else $error("undefined status code on output");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != cidm_pkg::ST_OK) |-> out_idx_q == '0)
		else $error("index carried with a failing status");
`endif

endmodule
